[design/wsnr_pkg.sv]
// shared types and constants for the weighted sampler
package wsnr_pkg;

    localparam int RAND_BITS      = 31;
    localparam int RAND_CNT_BITS  = 5;
    localparam int WEIGHT_IN_BITS = 31;
    localparam int SEL_BITS       = 6;
    localparam int STATUS_BITS    = 2;

    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_ZERO  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B
    } t_state;

endpackage

[design/wsnr_mod.sv]
// bit-serial restoring remainder unit, one numerator bit per cycle
module wsnr_mod #(
    parameter int TOTAL_BITS = 37
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [wsnr_pkg::RAND_BITS-1:0]      i_num,
    input  logic [TOTAL_BITS-1:0]               i_div,
    output logic                                o_done,
    output logic [TOTAL_BITS-1:0]               o_rem
);

    logic                                   r_busy;
    logic                                   r_done;
    logic [wsnr_pkg::RAND_CNT_BITS-1:0]     r_cnt;
    logic [wsnr_pkg::RAND_BITS-1:0]         r_num;
    logic [TOTAL_BITS-1:0]                  r_div;
    logic [TOTAL_BITS-1:0]                  r_rem;
    logic [TOTAL_BITS:0]                    trial;
    logic [TOTAL_BITS:0]                    diff;
    logic                                   last_step;

    // shift in the next numerator bit, subtract when it fits
    assign trial     = {r_rem, r_num[wsnr_pkg::RAND_BITS-1]};
    assign diff      = trial - {1'b0, r_div};
    assign last_step = (r_cnt == wsnr_pkg::RAND_CNT_BITS'(wsnr_pkg::RAND_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_div <= i_div;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[wsnr_pkg::RAND_BITS-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= diff[TOTAL_BITS-1:0];
            end else begin
                r_rem <= trial[TOTAL_BITS-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[design/weighted_sample_no_replacement.sv]
// roulette-wheel sampler without replacement over a stored weight set
// load: no result, busy stays low
// draw on an empty set or zero remaining weight: result in the cycle after accept
// normal draw: the 31-step serial remainder, then a scan of N entries (1 to MAX_ITEMS)
// with one stored entry read per scan cycle
// reset (synchronous, active low) clears count, draws and total; the store is not cleared
// results are strobed for one cycle on o_valid and cannot be stalled
module weighted_sample_no_replacement #(
    parameter int MAX_ITEMS   = 64,
    parameter int WEIGHT_BITS = 31
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_func,
    input  logic                                  i_is_first,
    input  logic [wsnr_pkg::WEIGHT_IN_BITS-1:0]   i_weight,
    input  logic [wsnr_pkg::RAND_BITS-1:0]        i_rand_value,
    output logic                                  o_valid,
    output logic [wsnr_pkg::SEL_BITS-1:0]         o_selected_index,
    output logic [wsnr_pkg::STATUS_BITS-1:0]      o_status
);

    localparam int IW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int TW  = WEIGHT_BITS + IW;
    localparam int EW  = WEIGHT_BITS + IW;
    localparam int WIN = (WEIGHT_BITS < wsnr_pkg::WEIGHT_IN_BITS) ? WEIGHT_BITS
                                                                 : wsnr_pkg::WEIGHT_IN_BITS;

    wsnr_pkg::t_state r_state;
    wsnr_pkg::t_state n_state;

    // set bookkeeping
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_draws;
    logic [TW-1:0]          r_total;

    // scan state
    logic [IW-1:0]          r_k;
    logic [TW-1:0]          r_sum;
    logic [TW-1:0]          r_target;
    logic [IW-1:0]          r_hit_k;
    logic [WEIGHT_BITS-1:0] r_hit_w;
    logic [IW-1:0]          r_hit_i;

    // result register
    logic                                 r_valid;
    logic [wsnr_pkg::SEL_BITS-1:0]        r_sel;
    logic [wsnr_pkg::STATUS_BITS-1:0]     r_status;

    // entry store: {original index, weight}
    logic [EW-1:0]          r_mem [MAX_ITEMS];
    logic [EW-1:0]          r_rd_data;
    logic                   mem_we;
    logic [IW-1:0]          mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [IW-1:0]          mem_raddr;

    logic                   accept;
    logic                   load_fire;
    logic                   draw_fire;
    logic                   set_empty;
    logic                   set_zero;
    logic [CW-1:0]          load_pos;
    logic                   load_room;
    logic [WEIGHT_BITS-1:0] w_in;
    logic [WEIGHT_BITS-1:0] rd_w;
    logic [IW-1:0]          rd_i;
    logic [TW-1:0]          sum_next;
    logic                   scan_last;
    logic                   scan_hit;
    logic [IW-1:0]          k_next;
    logic [TW-1:0]          sub_w;

    logic                   mod_start;
    logic                   mod_done;
    logic [TW-1:0]          mod_rem;

    assign busy      = (r_state != wsnr_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign load_fire = accept && !i_func;
    assign draw_fire = accept && i_func;
    assign set_empty = (r_draws >= r_count);
    assign set_zero  = (r_total == '0);

    // a restart puts the new weight at position zero
    assign load_pos  = i_is_first ? '0 : r_count;
    assign load_room = (load_pos < CW'(MAX_ITEMS));
    assign w_in      = WEIGHT_BITS'(i_weight[WIN-1:0]);

    assign rd_w      = r_rd_data[WEIGHT_BITS-1:0];
    assign rd_i      = r_rd_data[EW-1:WEIGHT_BITS];
    assign sum_next  = r_sum + TW'(rd_w);
    assign scan_last = ((CW'(r_k) + CW'(1)) == r_count);
    // last undrawn entry is taken if nothing hit before it
    assign scan_hit  = (r_target <= sum_next) || scan_last;
    assign k_next    = r_k + 1'b1;

    // saturating removal of the drawn weight
    assign sub_w = (TW'(r_hit_w) <= r_total) ? TW'(r_hit_w) : r_total;

    wsnr_mod #(
        .TOTAL_BITS (TW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_num   (i_rand_value),
        .i_div   (r_total),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wsnr_pkg::S_IDLE: begin
                if (draw_fire && !set_empty && !set_zero) begin
                    n_state = wsnr_pkg::S_MOD;
                end
            end
            wsnr_pkg::S_MOD: begin
                if (mod_done) begin
                    n_state = wsnr_pkg::S_SCAN;
                end
            end
            wsnr_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_state = wsnr_pkg::S_SWAP_A;
                end
            end
            wsnr_pkg::S_SWAP_A: n_state = wsnr_pkg::S_SWAP_B;
            wsnr_pkg::S_SWAP_B: n_state = wsnr_pkg::S_IDLE;
            default:            n_state = wsnr_pkg::S_IDLE;
        endcase
    end

    // store and remainder unit control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = load_pos[IW-1:0];
        mem_wdata = {load_pos[IW-1:0], w_in};
        mem_raddr = r_draws[IW-1:0];
        mod_start = 1'b0;
        case (r_state)
            wsnr_pkg::S_IDLE: begin
                mem_we    = load_fire && load_room;
                mod_start = draw_fire && !set_empty && !set_zero;
            end
            wsnr_pkg::S_MOD: begin
                // keep the first undrawn entry on the read port
                mem_raddr = r_draws[IW-1:0];
            end
            wsnr_pkg::S_SCAN: begin
                // on a hit, fetch the swap partner at the drawn boundary
                mem_raddr = scan_hit ? r_draws[IW-1:0] : k_next;
            end
            wsnr_pkg::S_SWAP_A: begin
                mem_we    = 1'b1;
                mem_waddr = r_hit_k;
                mem_wdata = r_rd_data;
            end
            wsnr_pkg::S_SWAP_B: begin
                mem_we    = 1'b1;
                mem_waddr = r_draws[IW-1:0];
                mem_wdata = {r_hit_i, r_hit_w};
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wsnr_pkg::S_IDLE;
            r_count <= '0;
            r_draws <= '0;
            r_total <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (load_fire) begin
                if (i_is_first) begin
                    r_draws <= '0;
                end
                if (load_room) begin
                    r_count <= load_pos + 1'b1;
                    r_total <= (i_is_first ? '0 : r_total) + TW'(w_in);
                end else if (i_is_first) begin
                    r_count <= '0;
                    r_total <= '0;
                end
            end
            if (draw_fire && (set_empty || set_zero)) begin
                r_valid <= 1'b1;
            end
            if (r_state == wsnr_pkg::S_SWAP_B) begin
                r_valid <= 1'b1;
                r_draws <= r_draws + 1'b1;
                r_total <= r_total - sub_w;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (draw_fire) begin
            r_sel    <= '0;
            r_status <= set_empty ? wsnr_pkg::ST_EMPTY : wsnr_pkg::ST_ZERO;
        end
        if (r_state == wsnr_pkg::S_MOD && mod_done) begin
            r_k      <= r_draws[IW-1:0];
            r_sum    <= '0;
            r_target <= mod_rem + 1'b1;
        end
        if (r_state == wsnr_pkg::S_SCAN) begin
            r_sum <= sum_next;
            r_k   <= k_next;
            if (scan_hit) begin
                r_hit_k <= r_k;
                r_hit_w <= rd_w;
                r_hit_i <= rd_i;
            end
        end
        if (r_state == wsnr_pkg::S_SWAP_B) begin
            r_sel    <= wsnr_pkg::SEL_BITS'(r_hit_i);
            r_status <= wsnr_pkg::ST_OK;
        end
    end

    assign o_valid          = r_valid;
    assign o_selected_index = r_sel;
    assign o_status         = r_status;

    // draw on an exhausted set answers on the next cycle
    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (draw_fire && set_empty) |=> (o_valid && o_status == wsnr_pkg::ST_EMPTY))
        else $error("empty draw did not report exhaustion");

    // drawn region never passes the loaded set
    a_draws_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draws <= r_count)
        else $error("draw count passed item count");

    // scan stays inside the loaded entries
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wsnr_pkg::S_SCAN) |-> (CW'(r_k) < r_count))
        else $error("scan index outside loaded set");

    // a good result only follows the swap
    a_ok_after_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == wsnr_pkg::ST_OK) |-> ($past(r_state) == wsnr_pkg::S_SWAP_B))
        else $error("ok result without a completed swap");

endmodule

[sim/sample_checker.sv]
// draw predictor and result checker for the weighted sampler
`timescale 1ns / 100ps

package sample_tb_pkg;
    typedef enum logic {
        FN_LOAD = 1'b0,
        FN_DRAW = 1'b1
    } t_func;
    localparam int SET_CAPACITY = 64;
endpackage

module sample_checker import wsnr_pkg::*, sample_tb_pkg::*; #(
    parameter int WEIGHT_BITS = 31
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic                      i_func,
    input  logic                      i_is_first,
    input  logic [WEIGHT_IN_BITS-1:0] i_weight,
    input  logic [RAND_BITS-1:0]      i_rand_value,
    input  logic                      i_valid,
    input  logic [SEL_BITS-1:0]       i_selected_index,
    input  logic [STATUS_BITS-1:0]    i_status,
    output int                        o_mismatches,
    output int                        o_pending,
    output int                        o_loads,
    output int                        o_ignored_loads,
    output int                        o_picked,
    output int                        o_exhausted,
    output int                        o_weightless
);

    localparam logic [WEIGHT_IN_BITS-1:0] WEIGHT_MASK =
        WEIGHT_IN_BITS'((64'd1 << WEIGHT_BITS) - 64'd1);

    typedef struct packed {
        logic [SEL_BITS-1:0]    index;
        logic [STATUS_BITS-1:0] status;
    } t_draw_result;

    // model of the stored set: weights and original positions, swapped as drawn
    logic [WEIGHT_IN_BITS-1:0] slot_weight [SET_CAPACITY];
    logic [SEL_BITS-1:0]       slot_origin [SET_CAPACITY];
    int                        loaded;
    int                        drawn;
    logic [36:0]               weight_left;
    t_draw_result              draws_due [$];

    int mismatches    = 0;
    int due_count     = 0;
    int loads         = 0;
    int ignored_loads = 0;
    int picked        = 0;
    int exhausted     = 0;
    int weightless    = 0;

    assign o_mismatches    = mismatches;
    assign o_pending       = due_count;
    assign o_loads         = loads;
    assign o_ignored_loads = ignored_loads;
    assign o_picked        = picked;
    assign o_exhausted     = exhausted;
    assign o_weightless    = weightless;

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic predict_item(input logic func, input logic first,
                                input logic [WEIGHT_IN_BITS-1:0] w_in,
                                input logic [RAND_BITS-1:0] rnd);
        t_draw_result              res;
        logic [63:0]               target;
        logic [63:0]               running;
        logic [WEIGHT_IN_BITS-1:0] w;
        logic [WEIGHT_IN_BITS-1:0] hit_weight;
        logic [SEL_BITS-1:0]       hit_origin;
        int                        hit;
        bit                        found;
        w = w_in & WEIGHT_MASK;
        if (func == FN_LOAD) begin
            if (first) begin
                loaded      = 0;
                drawn       = 0;
                weight_left = '0;
            end
            if (loaded < SET_CAPACITY) begin
                slot_weight[loaded] = w;
                slot_origin[loaded] = SEL_BITS'(loaded);
                weight_left        += 37'(w);
                loaded++;
                loads++;
            end else begin
                ignored_loads++;
            end
            return;
        end
        res.index = '0;
        if (drawn >= loaded) begin
            res.status = ST_EMPTY;
            exhausted++;
        end else if (weight_left == '0) begin
            res.status = ST_ZERO;
            weightless++;
        end else begin
            // roulette position in 1..weight_left, first undrawn entry that covers it
            target  = 64'(rnd) % 64'(weight_left) + 64'd1;
            running = '0;
            hit     = loaded - 1;
            found   = 1'b0;
            for (int k = drawn; k < loaded; k++) begin
                running += 64'(slot_weight[k]);
                if (!found && target <= running) begin
                    hit   = k;
                    found = 1'b1;
                end
            end
            hit_weight         = slot_weight[hit];
            hit_origin         = slot_origin[hit];
            slot_weight[hit]   = slot_weight[drawn];
            slot_origin[hit]   = slot_origin[drawn];
            slot_weight[drawn] = hit_weight;
            slot_origin[drawn] = hit_origin;
            weight_left -= (37'(hit_weight) <= weight_left) ? 37'(hit_weight) : weight_left;
            drawn++;
            res.index  = hit_origin;
            res.status = ST_OK;
            picked++;
        end
        draws_due.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_draw_result want;
        if (!i_rst_n) begin
            loaded      = 0;
            drawn       = 0;
            weight_left = '0;
            draws_due.delete();
        end else begin
            // results first: they always belong to items accepted earlier
            if ($isunknown(i_valid)) begin
                report_mismatch("result strobe is unknown");
            end else if (i_valid) begin
                if (draws_due.size() == 0) begin
                    report_mismatch($sformatf("result index %0d status %0d with no draw waiting",
                                              i_selected_index, i_status));
                end else begin
                    want = draws_due.pop_front();
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_status, want.status));
                    end
                    if (i_selected_index !== want.index) begin
                        report_mismatch($sformatf("selected index %0d, expected %0d",
                                                  i_selected_index, want.index));
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_item(i_func, i_is_first, i_weight, i_rand_value);
            end
        end
        due_count = draws_due.size();
    end

endmodule

[sim/testbench.sv]
// top of the weighted sampler testbench: clock, reset, item stimulus and verdict
`timescale 1ns / 100ps

module testbench;
    import wsnr_pkg::*;
    import sample_tb_pkg::*;

    localparam int MAX_ITEMS    = SET_CAPACITY;
    localparam int WEIGHT_BITS  = 31;
    localparam int ITEM_TARGET  = 1300;
    localparam int QUIET_TAIL   = 150;   // the last items of the run go without gaps
    localparam int STALL_LIMIT  = 2000;  // well above the slowest draw plus the longest item gap
    localparam int DRAIN_CYCLES = 150;

    localparam logic [WEIGHT_IN_BITS-1:0] W_MAX = '1;
    localparam logic [RAND_BITS-1:0]      R_MAX = '1;

    // how the weights of one set are spread
    typedef enum int {
        MIX_FULL,
        MIX_SMALL,
        MIX_EXTREME,
        MIX_LOPSIDED
    } t_mix;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic                      i_func;
    logic                      i_is_first;
    logic [WEIGHT_IN_BITS-1:0] i_weight;
    logic [RAND_BITS-1:0]      i_rand_value;
    logic                      o_valid;
    logic [SEL_BITS-1:0]       o_selected_index;
    logic [STATUS_BITS-1:0]    o_status;

    int mismatches;
    int pending;
    int loads;
    int ignored_loads;
    int picked;
    int exhausted;
    int weightless;

    // stimulus bookkeeping: items that count toward the target, and our view of the set fill
    int sent    = 0;
    int fill    = 0;
    int gap_pct = 0;

    weighted_sample_no_replacement #(
        .MAX_ITEMS   (MAX_ITEMS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_is_first       (i_is_first),
        .i_weight         (i_weight),
        .i_rand_value     (i_rand_value),
        .o_valid          (o_valid),
        .o_selected_index (o_selected_index),
        .o_status         (o_status)
    );

    sample_checker #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) draw_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_func           (i_func),
        .i_is_first       (i_is_first),
        .i_weight         (i_weight),
        .i_rand_value     (i_rand_value),
        .i_valid          (o_valid),
        .i_selected_index (o_selected_index),
        .i_status         (o_status),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_loads          (loads),
        .o_ignored_loads  (ignored_loads),
        .o_picked         (picked),
        .o_exhausted      (exhausted),
        .o_weightless     (weightless)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: ends the run when neither an item nor a result moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid || !i_rst_n) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout after %0d cycles with no progress", STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [WEIGHT_IN_BITS-1:0] pick_weight(input t_mix mix);
        case (mix)
            MIX_FULL: begin
                return WEIGHT_IN_BITS'($urandom);
            end
            MIX_SMALL: begin
                // zero weights turn up often here
                return WEIGHT_IN_BITS'($urandom_range(0, 15));
            end
            MIX_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return W_MAX;
                    2:       return W_MAX - WEIGHT_IN_BITS'($urandom_range(1, 7));
                    default: return WEIGHT_IN_BITS'($urandom);
                endcase
            end
            default: begin
                // mostly tiny weights with an occasional huge one
                if ($urandom_range(0, 9) == 0) begin
                    return W_MAX - WEIGHT_IN_BITS'($urandom_range(0, 3));
                end
                return WEIGHT_IN_BITS'($urandom_range(0, 3));
            end
        endcase
    endfunction

    function automatic logic [RAND_BITS-1:0] pick_rand();
        case ($urandom_range(0, 19))
            0, 1:    return '0;
            2, 3:    return R_MAX;
            4, 5, 6: return RAND_BITS'($urandom_range(0, 7));
            7:       return R_MAX - RAND_BITS'($urandom_range(1, 15));
            default: return RAND_BITS'($urandom);
        endcase
    endfunction

    // offer one item and hold it until the block takes it
    task automatic send_item(input t_func fn, input logic first,
                             input logic [WEIGHT_IN_BITS-1:0] w,
                             input logic [RAND_BITS-1:0] rnd);
        if (gap_pct > 0 && sent < ITEM_TARGET - QUIET_TAIL
                && $urandom_range(1, 100) <= gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= fn;
        i_is_first   <= first;
        i_weight     <= w;
        i_rand_value <= rnd;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // loads past capacity are ignored by the block and do not count
        if (fn == FN_LOAD) begin
            if (first) begin
                fill = 0;
            end
            if (fill < MAX_ITEMS) begin
                fill++;
                sent++;
            end
        end else begin
            sent++;
        end
    endtask

    initial begin
        int   set_size;
        int   n_draws;
        t_mix mix;
        bit   restart;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_func       <= FN_LOAD;
        i_is_first   <= 1'b0;
        i_weight     <= '0;
        i_rand_value <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        gap_pct = 30;
        // draw right after reset: nothing loaded, so all drawn
        send_item(FN_DRAW, 1'b0, '0, '0);
        // set of two zero weights: remaining weight zero
        send_item(FN_LOAD, 1'b1, '0, R_MAX);
        send_item(FN_LOAD, 1'b0, '0, '0);
        send_item(FN_DRAW, 1'b0, W_MAX, R_MAX);
        // extreme weights with a zero weight in the middle
        send_item(FN_LOAD, 1'b1, W_MAX, '0);
        send_item(FN_LOAD, 1'b0, WEIGHT_IN_BITS'(1), '0);
        send_item(FN_LOAD, 1'b0, '0, '0);
        send_item(FN_LOAD, 1'b0, W_MAX, '0);
        send_item(FN_DRAW, 1'b0, '0, R_MAX);
        // restart flag on a draw is ignored
        send_item(FN_DRAW, 1'b1, '0, '0);
        send_item(FN_DRAW, 1'b0, '0, RAND_BITS'(31'h2AAA_AAAA));
        // only the zero weight item is left
        send_item(FN_DRAW, 1'b0, '0, RAND_BITS'(31'h5555_5555));
        // load after draws joins the undrawn region
        send_item(FN_LOAD, 1'b0, WEIGHT_IN_BITS'(5), '0);
        send_item(FN_DRAW, 1'b0, '0, RAND_BITS'(31'h5555_5555));
        send_item(FN_DRAW, 1'b0, '0, R_MAX);
        // restart in the middle of drawing
        send_item(FN_LOAD, 1'b1, WEIGHT_IN_BITS'(31'h2AAA_AAAA), '0);
        send_item(FN_LOAD, 1'b0, WEIGHT_IN_BITS'(31'h5555_5555), '0);
        send_item(FN_DRAW, 1'b0, '0, RAND_BITS'(1));
        send_item(FN_LOAD, 1'b1, WEIGHT_IN_BITS'(1), '0);
        send_item(FN_DRAW, 1'b0, W_MAX, '0);
        send_item(FN_DRAW, 1'b0, '0, '0);

        // random part: mostly load a set then draw it down, some noise in between
        while (sent < ITEM_TARGET) begin
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
            mix     = t_mix'($urandom_range(0, 3));
            case ($urandom_range(0, 19))
                0: begin
                    set_size = $urandom_range(60, 70);  // may run past capacity
                end
                1, 2: begin
                    set_size = $urandom_range(13, 40);
                end
                default: begin
                    set_size = $urandom_range(1, 12);
                end
            endcase
            if ($urandom_range(0, 19) == 0) begin
                // noise: anything in any order
                repeat ($urandom_range(1, 6)) begin
                    send_item(t_func'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              pick_weight(mix), pick_rand());
                end
            end else begin
                // now and then append to the previous set instead of restarting
                restart = ($urandom_range(0, 9) != 0);
                for (int i = 0; i < set_size; i++) begin
                    send_item(FN_LOAD, (i == 0) && restart, pick_weight(mix), pick_rand());
                end
                if (set_size > MAX_ITEMS) begin
                    set_size = MAX_ITEMS;
                end
                // most sets are drawn to exhaustion or past it, some only partly
                n_draws = ($urandom_range(0, 3) == 0) ? $urandom_range(0, set_size)
                                                      : set_size + $urandom_range(0, 2);
                for (int i = 0; i < n_draws; i++) begin
                    if ($urandom_range(0, 14) == 0) begin
                        send_item(FN_LOAD, 1'b0, pick_weight(mix), pick_rand());
                    end
                    send_item(FN_DRAW, 1'($urandom_range(0, 1)),
                              WEIGHT_IN_BITS'($urandom), pick_rand());
                end
            end
        end

        // drain: wait for outstanding draws, then give the block time to misbehave
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d weight loads (%0d ignored at a full set) and %0d draws",
                 loads, ignored_loads, picked + exhausted + weightless);
        $display("draws: %0d picked, %0d on a fully drawn set, %0d with no weight left",
                 picked, exhausted, weightless);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
